// File: design/tcse_pkg.sv
// ============================================================================
// tcse_pkg
// Shared constants, command codes and controller/datapath bundles for the
// text console screen engine.
// ============================================================================
package tcse_pkg;

   // screen geometry
   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TERMINALS = 4;
   localparam int CELLS     = COLUMNS * ROWS;
   localparam int MEM_DEPTH = TERMINALS * CELLS;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int CELL_W    = $clog2(CELLS + 1);
   localparam int CNT_W     = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS);

   // beat field widths
   localparam int CMD_W    = 3;
   localparam int TERM_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;

   localparam logic [CHAR_W-1:0] BLANK = 8'h20;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUT     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_NEWLINE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BACK    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

   function automatic logic term_ok(input logic [TERM_W-1:0] t);
      return (32'(t) < TERMINALS);
   endfunction

   typedef struct packed {
      logic req_ready;
      logic capture;
      logic init_write;
      logic cnt_zero;
      logic cnt_bottom;
      logic cnt_inc;
      logic copy_read;
      logic fill_write;
      logic put_step;
      logic bs_step;
      logic nl_step;
      logic cur_clear;
      logic cur_scroll;
      logic read_capture;
      logic report;
      logic disp_sel;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic             init_last;
      logic             copy_last;
      logic             fill_last;
      logic [CMD_W-1:0] cmd_code;
      logic             term_valid;
      logic             cur_full;
      logic             nl_scroll;
      logic             bs_ok;
      logic             rsp_free;
   } dp_status_type;

endpackage

// File: design/tcse_req_if.sv
// ============================================================================
// tcse_req_if
// Command channel: valid/ready plus one command beat.
// ============================================================================
interface tcse_req_if import tcse_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [TERM_W-1:0]  target_terminal;
   logic [CHAR_W-1:0]  char_value;
   logic [INDEX_W-1:0] cell_index;
   logic               end_of_run;

   modport source (output valid, command, target_terminal, char_value, cell_index,
                   end_of_run, input ready);
   modport sink   (input valid, command, target_terminal, char_value, cell_index,
                   end_of_run, output ready);
endinterface

// File: design/tcse_rsp_if.sv
// ============================================================================
// tcse_rsp_if
// Result channel: valid/ready plus one result beat.
// ============================================================================
interface tcse_rsp_if import tcse_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   read_char;
   logic [CURSOR_W-1:0] target_cursor;
   logic [CURSOR_W-1:0] display_cursor;
   logic                scrolled;
   logic                run_done;

   modport source (output valid, read_char, target_cursor, display_cursor, scrolled,
                   run_done, input ready);
   modport sink   (input valid, read_char, target_cursor, display_cursor, scrolled,
                   run_done, output ready);
endinterface

// File: design/tcse_csr_if.sv
// ============================================================================
// tcse_csr_if
// Register write channel for the visible terminal select.
// ============================================================================
interface tcse_csr_if import tcse_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [TERM_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: design/tcse_ctrl.sv
// ============================================================================
// tcse_ctrl
// Sequencer: clearing pass, command decode, copy/fill sweeps, result hand-off.
// ============================================================================
module tcse_ctrl import tcse_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam logic [3:0] ST_INIT   = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_DECODE = 4'd2;
   localparam logic [3:0] ST_COPY   = 4'd3;
   localparam logic [3:0] ST_DRAIN  = 4'd4;
   localparam logic [3:0] ST_FILL   = 4'd5;
   localparam logic [3:0] ST_PUT    = 4'd6;
   localparam logic [3:0] ST_RDWAIT = 4'd7;
   localparam logic [3:0] ST_REPORT = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       scroll_ff, scroll_in;   // fill sweep belongs to a scroll

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         scroll_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         scroll_ff <= scroll_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      scroll_in = scroll_ff;
      case (state_ff)
         ST_INIT: begin
            cmd.init_write = 1'b1;
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_REPORT;
            if (status.term_valid) begin
               case (status.cmd_code)
                  CMD_CLEAR: begin
                     cmd.cnt_zero = 1'b1;
                     scroll_in    = 1'b0;
                     state_in     = ST_FILL;
                  end
                  CMD_PUT: begin
                     if (status.cur_full) begin
                        cmd.cnt_zero = 1'b1;
                        scroll_in    = 1'b1;
                        state_in     = ST_COPY;
                     end else begin
                        state_in = ST_PUT;
                     end
                  end
                  CMD_NEWLINE: begin
                     if (status.nl_scroll) begin
                        cmd.cnt_zero = 1'b1;
                        scroll_in    = 1'b1;
                        state_in     = ST_COPY;
                     end else begin
                        cmd.nl_step = 1'b1;
                     end
                  end
                  CMD_BACK: begin
                     cmd.bs_step = status.bs_ok;
                  end
                  CMD_READ: begin
                     state_in = ST_RDWAIT;
                  end
                  default: begin
                     state_in = ST_REPORT;
                  end
               endcase
            end
         end
         ST_COPY: begin
            cmd.copy_read = 1'b1;
            cmd.cnt_inc   = 1'b1;
            if (status.copy_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            cmd.cnt_bottom = 1'b1;
            state_in       = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill_write = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.fill_last) begin
               if (scroll_ff) begin
                  cmd.cur_scroll = 1'b1;
                  state_in = (status.cmd_code == CMD_PUT) ? ST_PUT : ST_REPORT;
               end else begin
                  cmd.cur_clear = 1'b1;
                  state_in      = ST_REPORT;
               end
            end
         end
         ST_PUT: begin
            cmd.put_step = 1'b1;
            state_in     = ST_REPORT;
         end
         ST_RDWAIT: begin
            cmd.read_capture = 1'b1;
            state_in         = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.disp_sel = 1'b1;
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/tcse_datapath.sv
// ============================================================================
// tcse_datapath
// Screen memory, cursors, sweep counter, visible select and result register.
// ============================================================================
module tcse_datapath import tcse_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       status,
   // command beat
   input  logic [CMD_W-1:0]    req_command,
   input  logic [TERM_W-1:0]   req_target_terminal,
   input  logic [CHAR_W-1:0]   req_char_value,
   input  logic [INDEX_W-1:0]  req_cell_index,
   input  logic                req_end_of_run,
   // register write
   input  logic                csr_valid,
   input  logic [TERM_W-1:0]   csr_data,
   // result beat
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [CHAR_W-1:0]   rsp_read_char,
   output logic [CURSOR_W-1:0] rsp_target_cursor,
   output logic [CURSOR_W-1:0] rsp_display_cursor,
   output logic                rsp_scrolled,
   output logic                rsp_run_done
);

   // latched beat
   logic [CMD_W-1:0]   cmd_ff;
   logic [TERM_W-1:0]  term_ff;
   logic [CHAR_W-1:0]  char_ff;
   logic [INDEX_W-1:0] cell_ff;
   logic               eor_ff;
   logic [MEM_AW-1:0]  base_ff;

   logic [TERM_W-1:0]  vis_ff;
   logic [MEM_AW-1:0]  init_cnt_ff;
   logic [CNT_W-1:0]   cnt_ff;

   logic [CELL_W-1:0]  cursor_ff [TERMINALS];
   logic [COL_W-1:0]   col_ff    [TERMINALS];

   logic [CHAR_W-1:0]  screen_mem [MEM_DEPTH];
   logic [CHAR_W-1:0]  rdata_ff;
   logic               pipe_valid_ff;
   logic [CNT_W-1:0]   pipe_idx_ff;

   logic [CHAR_W-1:0]  rd_ff;
   logic               scr_ff;
   logic [CELL_W-1:0]  tcur_ff;

   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [CURSOR_W-1:0] rsp_tcur_ff;
   logic [CURSOR_W-1:0] rsp_dcur_ff;
   logic                rsp_scr_ff;
   logic                rsp_eor_ff;

   logic [TERM_W-1:0]  sel_term;
   logic [CELL_W-1:0]  cur_rd;
   logic [COL_W-1:0]   col_rd;
   logic               cell_ok;
   logic [MEM_AW-1:0]  raddr;
   logic               wr_en;
   logic [MEM_AW-1:0]  wr_addr;
   logic [CHAR_W-1:0]  wr_data;

   assign sel_term = cmd.disp_sel ? vis_ff : term_ff;
   assign cur_rd   = cursor_ff[sel_term];
   assign col_rd   = col_ff[term_ff];
   assign cell_ok  = (32'(cell_ff) < CELLS);

   assign status.init_last  = (init_cnt_ff == MEM_AW'(MEM_DEPTH - 1));
   assign status.copy_last  = (cnt_ff == CNT_W'(CELLS - COLUMNS - 1));
   assign status.fill_last  = (cnt_ff == CNT_W'(CELLS - 1));
   assign status.cmd_code   = cmd_ff;
   assign status.term_valid = term_ok(term_ff);
   assign status.cur_full   = (cur_rd >= CELL_W'(CELLS));
   assign status.nl_scroll  = (cur_rd > CELL_W'(CELLS - COLUMNS));
   assign status.bs_ok      = (cur_rd != '0) && (cur_rd <= CELL_W'(CELLS));
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // beat capture and per-command flags
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= req_command;
         term_ff <= req_target_terminal;
         char_ff <= req_char_value;
         cell_ff <= req_cell_index;
         eor_ff  <= req_end_of_run;
         base_ff <= MEM_AW'(req_target_terminal) * MEM_AW'(CELLS);
         rd_ff   <= '0;
         scr_ff  <= 1'b0;
      end else begin
         if (cmd.read_capture && cell_ok) rd_ff <= rdata_ff;
         if (cmd.cur_scroll)              scr_ff <= 1'b1;
      end
      if (cmd.report) tcur_ff <= status.term_valid ? cur_rd : '0;
   end

   // visible terminal select
   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff <= '0;
      end else if (csr_valid) begin
         vis_ff <= csr_data;
      end
   end

   // clearing pass and sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         init_cnt_ff <= '0;
      end else if (cmd.init_write) begin
         init_cnt_ff <= init_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cnt_zero) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_bottom) begin
         cnt_ff <= CNT_W'(CELLS - COLUMNS);
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // cursors, with column kept alongside so row start needs no division
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TERMINALS; i++) begin
            cursor_ff[i] <= '0;
            col_ff[i]    <= '0;
         end
      end else begin
         if (cmd.cur_clear) begin
            cursor_ff[term_ff] <= '0;
            col_ff[term_ff]    <= '0;
         end else if (cmd.cur_scroll) begin
            cursor_ff[term_ff] <= CELL_W'(CELLS - COLUMNS);
            col_ff[term_ff]    <= '0;
         end else if (cmd.put_step) begin
            cursor_ff[term_ff] <= cur_rd + 1'b1;
            col_ff[term_ff]    <= (col_rd == COL_W'(COLUMNS - 1)) ? '0 : col_rd + 1'b1;
         end else if (cmd.nl_step) begin
            cursor_ff[term_ff] <= cur_rd + CELL_W'(COLUMNS) - CELL_W'(col_rd);
            col_ff[term_ff]    <= '0;
         end else if (cmd.bs_step) begin
            cursor_ff[term_ff] <= cur_rd - 1'b1;
            col_ff[term_ff]    <= (col_rd == '0) ? COL_W'(COLUMNS - 1) : col_rd - 1'b1;
         end
      end
   end

   // screen memory: one write port, one registered read port
   assign raddr = cmd.copy_read ? base_ff + MEM_AW'(cnt_ff) + MEM_AW'(COLUMNS)
                                : base_ff + MEM_AW'(cell_ff);

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = base_ff + MEM_AW'(cnt_ff);
      wr_data = BLANK;
      if (cmd.init_write) begin
         wr_addr = init_cnt_ff;
      end else if (pipe_valid_ff) begin
         wr_addr = base_ff + MEM_AW'(pipe_idx_ff);
         wr_data = rdata_ff;
      end else if (cmd.fill_write) begin
         wr_addr = base_ff + MEM_AW'(cnt_ff);
      end else if (cmd.put_step) begin
         wr_addr = base_ff + MEM_AW'(cur_rd);
         wr_data = char_ff;
      end else if (cmd.bs_step) begin
         wr_addr = base_ff + MEM_AW'(cur_rd) - 1'b1;
         wr_data = char_ff;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) screen_mem[wr_addr] <= wr_data;
      rdata_ff <= screen_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= cmd.copy_read;
      end
      pipe_idx_ff <= cnt_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_char_ff <= rd_ff;
         rsp_tcur_ff <= CURSOR_W'(tcur_ff);
         rsp_dcur_ff <= term_ok(vis_ff) ? CURSOR_W'(cur_rd) : '0;
         rsp_scr_ff  <= scr_ff;
         rsp_eor_ff  <= eor_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_char      = rsp_char_ff;
   assign rsp_target_cursor  = rsp_tcur_ff;
   assign rsp_display_cursor = rsp_dcur_ff;
   assign rsp_scrolled       = rsp_scr_ff;
   assign rsp_run_done       = rsp_eor_ff;

endmodule

// File: design/text_console_screen_engine_top.sv
// ============================================================================
// text_console_screen_engine_top
// Put goes decode, put, report, finish; read goes decode, read wait,
// report, finish; newline without scroll, backspace and unused codes go
// decode, report, finish. Clear fills every cell of the screen with blanks;
// a scroll adds a 1920-cell copy, a drain state and an 80-cell blank row.
// One command in flight; the next beat is taken the cycle after the result is
// loaded. After reset a clearing pass fills all 8000 cells with spaces.
// ============================================================================
module text_console_screen_engine_top import tcse_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   tcse_req_if.sink   req_bus,
   tcse_rsp_if.source rsp_bus,
   tcse_csr_if.sink   csr_bus
);

   // Controller and datapath talk only through these two bundles.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Commands are taken only in the idle state; the result register frees the
   // result side so a beat can be taken while a result waits to be drained.
   assign req_bus.ready = cmd.req_ready;

   // The visible-terminal register is always writable.
   assign csr_bus.ready = 1'b1;

   tcse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: 8000-cell screen store (one write, one registered read port),
   // per-terminal cursor and column, sweep counter and the result register.
   tcse_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_command         (req_bus.command),
      .req_target_terminal (req_bus.target_terminal),
      .req_char_value      (req_bus.char_value),
      .req_cell_index      (req_bus.cell_index),
      .req_end_of_run      (req_bus.end_of_run),
      .csr_valid           (csr_bus.valid),
      .csr_data            (csr_bus.data),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_read_char       (rsp_bus.read_char),
      .rsp_target_cursor   (rsp_bus.target_cursor),
      .rsp_display_cursor  (rsp_bus.display_cursor),
      .rsp_scrolled        (rsp_bus.scrolled),
      .rsp_run_done        (rsp_bus.run_done)
   );

endmodule

// File: dv/text_console_screen_engine_top_test.sv
// ============================================================================
// text_console_screen_engine_top_test
// Self-checking bench for the text console screen engine. Command beats are
// driven on the request channel with random gaps; each accepted beat is run
// through a shadow of the four screens and their cursors, and the predicted
// result beat is compared field by field with what the engine returns. The
// visible terminal is reselected between phases while the engine is idle.
// ============================================================================
module text_console_screen_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tcse_pkg::*;

   // Cycles with no beat accepted on any channel before the run is abandoned.
   // The slowest legitimate quiet spell is the clearing pass after reset; a clear
   // or a scroll and the long receiver hold-off are all shorter, so this leaves a
   // wide margin.
   localparam int QUIET_LIMIT = 30000;

   // Command codes the engine does not decode: no operation, read_char zero.
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

   // First cell of the bottom row; a newline beyond it scrolls.
   localparam int LAST_ROW  = CELLS - COLUMNS;
   localparam int INDEX_MAX = (1 << INDEX_W) - 1;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [TERM_W-1:0]  target_terminal;
      logic [CHAR_W-1:0]  char_value;
      logic [INDEX_W-1:0] cell_index;
      logic               end_of_run;
   } console_cmd_t;

   typedef struct packed {
      logic [CHAR_W-1:0]   read_char;
      logic [CURSOR_W-1:0] target_cursor;
      logic [CURSOR_W-1:0] display_cursor;
      logic                scrolled;
      logic                run_done;
   } console_result_t;

   logic clock;
   logic reset;

   tcse_req_if req_bus ();
   tcse_rsp_if rsp_bus ();
   tcse_csr_if csr_bus ();

   text_console_screen_engine_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ------------------------------------------------------------------------
   // Shadow of the engine: every screen's characters, every cursor and the
   // visible terminal select. Updated at the edge where a beat is accepted.
   // ------------------------------------------------------------------------
   logic [CHAR_W-1:0] screen_mem [MEM_DEPTH];
   int                cursor_at  [TERMINALS];
   int                visible_now = 0;

   // Result beats predicted but not yet returned, oldest first.
   console_result_t   results_due [$];

   int error_count  = 0;
   int quiet_cycles = 0;
   int useful_items = 0;   // accepted beats that the engine acts on
   bit steady       = 1'b0; // set: neither side inserts gaps
   int hold_request = 0;   // long hold-off for the receiver to pick up

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [CURSOR_W-1:0] cursor_view(input int term);
      if (term >= TERMINALS)
         return '0;
      return CURSOR_W'(cursor_at[term]);
   endfunction

   // Rows move up one, bottom row goes blank, cursor parks at its start.
   function automatic void scroll_screen(input int term);
      int base;
      base = term * CELLS;
      for (int i = 0; i < LAST_ROW; i++)
         screen_mem[base + i] = screen_mem[base + i + COLUMNS];
      for (int i = LAST_ROW; i < CELLS; i++)
         screen_mem[base + i] = BLANK;
      cursor_at[term] = LAST_ROW;
   endfunction

   function automatic console_result_t console_apply(input console_cmd_t c);
      console_result_t r;
      int              term;
      int              base;
      int              cur;
      r    = '0;
      term = int'(c.target_terminal);
      if (term < TERMINALS) begin
         base = term * CELLS;
         cur  = cursor_at[term];
         case (c.command)
            CMD_CLEAR: begin
               for (int i = 0; i < CELLS; i++)
                  screen_mem[base + i] = BLANK;
               cursor_at[term] = 0;
            end
            CMD_PUT: begin
               // cursor past the last cell: scroll first, then write
               if (cur >= CELLS) begin
                  scroll_screen(term);
                  r.scrolled = 1'b1;
                  cur = cursor_at[term];
               end
               screen_mem[base + cur] = c.char_value;
               cursor_at[term] = cur + 1;
            end
            CMD_NEWLINE: begin
               if (cur > LAST_ROW) begin
                  scroll_screen(term);
                  r.scrolled = 1'b1;
               end else begin
                  cursor_at[term] = cur + COLUMNS - (cur % COLUMNS);
               end
            end
            CMD_BACK: begin
               // nothing happens at cell zero
               if (cur > 0 && cur <= CELLS) begin
                  screen_mem[base + cur - 1] = c.char_value;
                  cursor_at[term] = cur - 1;
               end
            end
            CMD_READ: begin
               if (int'(c.cell_index) < CELLS)
                  r.read_char = screen_mem[base + int'(c.cell_index)];
            end
            default: ;
         endcase
      end
      r.target_cursor  = cursor_view(term);
      r.display_cursor = cursor_view(visible_now);
      r.run_done       = c.end_of_run;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Observer: all three channels sampled at the rising edge. Checks result
   // beats, predicts from request beats, tracks the register, and counts
   // quiet cycles for the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : observe
      console_result_t want;
      console_cmd_t    seen;
      bit              moved;
      moved = 1'b0;
      if (rsp_bus.valid && rsp_bus.ready) begin
         moved = 1'b1;
         if (results_due.size() == 0) begin
            $error("result beat with nothing outstanding");
            error_count++;
         end else begin
            want = results_due.pop_front();
            check_field("read_char",      16'(want.read_char),      16'(rsp_bus.read_char));
            check_field("target_cursor",  16'(want.target_cursor),
                        16'(rsp_bus.target_cursor));
            check_field("display_cursor", 16'(want.display_cursor),
                        16'(rsp_bus.display_cursor));
            check_field("scrolled",       16'(want.scrolled),       16'(rsp_bus.scrolled));
            check_field("run_done",       16'(want.run_done),       16'(rsp_bus.run_done));
         end
      end
      if (req_bus.valid && req_bus.ready) begin
         moved                = 1'b1;
         seen.command         = req_bus.command;
         seen.target_terminal = req_bus.target_terminal;
         seen.char_value      = req_bus.char_value;
         seen.cell_index      = req_bus.cell_index;
         seen.end_of_run      = req_bus.end_of_run;
         results_due.push_back(console_apply(seen));
      end
      if (csr_bus.valid && csr_bus.ready) begin
         moved       = 1'b1;
         visible_now = int'(csr_bus.data);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("[text_console_screen_engine_top] ERROR");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Receiver: ready changes only at the falling edge. A hold request from
   // the sequencer becomes one long stall counted here.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!steady && $urandom_range(0, 3) == 0)
               stall_left = gap_length();
         end
      end
   end

   function automatic console_cmd_t command_beat(input logic [CMD_W-1:0] cmd, input int term,
                                                 input int ch, input int cell_sel,
                                                 input bit eor);
      console_cmd_t c;
      c.command         = cmd;
      c.target_terminal = TERM_W'(term);
      c.char_value      = CHAR_W'(ch);
      c.cell_index      = INDEX_W'(cell_sel);
      c.end_of_run      = eor;
      return c;
   endfunction

   // Entered and left at a falling edge. valid stays high when the next beat
   // follows with no gap, so it is never lowered and raised in one step.
   task automatic issue_command(input console_cmd_t c);
      int gap;
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.command         = c.command;
      req_bus.target_terminal = c.target_terminal;
      req_bus.char_value      = c.char_value;
      req_bus.cell_index      = c.cell_index;
      req_bus.end_of_run      = c.end_of_run;
      req_bus.valid           = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
      if (c.command <= CMD_READ)
         useful_items++;
   endtask

   // One command in flight: once every result is back the engine is idle.
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (results_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic select_display(input int term);
      drain_results();
      csr_bus.data  = TERM_W'(term);
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic walk_to_last_row(input int term);
      while (cursor_at[term] < LAST_ROW)
         issue_command(command_beat(CMD_NEWLINE, term, 0, 0, 1'b0));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Fresh screens after reset: blank cells, out-of-range reads, unused
   // codes and a backspace at cell zero.
   task automatic test_idle_screens();
      issue_command(command_beat(CMD_READ, 0, 8'hFF, 0, 1'b0));
      issue_command(command_beat(CMD_READ, 3, 8'h00, CELLS - 1, 1'b1));
      issue_command(command_beat(CMD_READ, 1, 8'h5A, CELLS, 1'b0));
      issue_command(command_beat(CMD_READ, 2, 8'hA5, INDEX_MAX, 1'b1));
      issue_command(command_beat(CMD_UNUSED_FIRST, 0, 8'hFF, INDEX_MAX, 1'b1));
      issue_command(command_beat(CMD_UNUSED_FIRST + 3'd1, 3, 8'h00, 0, 1'b0));
      issue_command(command_beat(CMD_UNUSED_LAST, 1, 8'h80, 1024, 1'b1));
      issue_command(command_beat(CMD_BACK, 2, 8'hAA, 0, 1'b0));
   endtask

   task automatic test_edit_commands();
      issue_command(command_beat(CMD_PUT, 0, 8'h00, 0, 1'b0));
      issue_command(command_beat(CMD_PUT, 0, 8'hFF, 0, 1'b1));
      issue_command(command_beat(CMD_NEWLINE, 0, 0, 0, 1'b0));
      issue_command(command_beat(CMD_PUT, 0, 8'h55, 0, 1'b0));
      issue_command(command_beat(CMD_BACK, 0, 8'hAA, 0, 1'b1));
      issue_command(command_beat(CMD_READ, 0, 0, 0, 1'b0));
      issue_command(command_beat(CMD_READ, 0, 0, 1, 1'b0));
      issue_command(command_beat(CMD_READ, 0, 0, COLUMNS, 1'b0));
      // visible terminal is 3 here, so display_cursor follows this one
      issue_command(command_beat(CMD_NEWLINE, 3, 0, 0, 1'b1));
   endtask

   task automatic test_clear_screen();
      issue_command(command_beat(CMD_PUT, 3, 8'h31, 0, 1'b0));
      issue_command(command_beat(CMD_CLEAR, 3, 8'hFF, INDEX_MAX, 1'b1));
      issue_command(command_beat(CMD_READ, 3, 0, COLUMNS, 1'b0));
   endtask

   // Terminal 1 is the visible one: bottom-row boundary for newline,
   // backspace from one past the last cell, put and newline scrolls.
   task automatic test_scroll_edges();
      walk_to_last_row(1);
      issue_command(command_beat(CMD_NEWLINE, 1, 0, 0, 1'b0));   // start of last row: no scroll
      issue_command(command_beat(CMD_BACK, 1, 8'h7E, 0, 1'b0));
      issue_command(command_beat(CMD_PUT, 1, 8'h41, 0, 1'b0));
      issue_command(command_beat(CMD_PUT, 1, 8'h42, 0, 1'b1));   // past the end: scrolls
      issue_command(command_beat(CMD_NEWLINE, 1, 0, 0, 1'b0));   // beyond row start: scrolls
      issue_command(command_beat(CMD_READ, 1, 0, LAST_ROW - COLUMNS - 1, 1'b0));
      issue_command(command_beat(CMD_READ, 1, 0, LAST_ROW - COLUMNS, 1'b0));
      issue_command(command_beat(CMD_READ, 1, 0, LAST_ROW, 1'b1));
   endtask

   // Receiver holds off for a long stretch while beats keep coming, so the
   // engine backs up and drops req ready.
   task automatic test_back_pressure();
      drain_results();
      steady       = 1'b1;
      hold_request = 400;
      for (int i = 0; i < 8; i++)
         issue_command(command_beat(CMD_PUT, i % TERMINALS, $urandom_range(0, 255),
                                    $urandom_range(0, INDEX_MAX), i == 7));
      steady = 1'b0;
   endtask

   task automatic run_random_phase(input int quota);
      int start_count;
      int r;
      int n;
      int term;
      int cell_sel;
      int q;
      start_count = useful_items;
      while (useful_items - start_count < quota) begin
         r    = $urandom_range(0, 99);
         term = $urandom_range(0, TERMINALS - 1);
         n    = $urandom_range(1, 30);
         if (r < 35) begin
            // a write buffer: run of characters, last one flagged
            for (int i = 0; i < n; i++)
               issue_command(command_beat(CMD_PUT, term, $urandom_range(0, 255),
                                          $urandom_range(0, INDEX_MAX), i == n - 1));
         end else if (r < 50) begin
            repeat ($urandom_range(1, 3))
               issue_command(command_beat(CMD_NEWLINE, term, $urandom_range(0, 255),
                                          $urandom_range(0, INDEX_MAX),
                                          1'($urandom_range(0, 1))));
         end else if (r < 60) begin
            repeat ($urandom_range(1, 5))
               issue_command(command_beat(CMD_BACK, term, $urandom_range(0, 255),
                                          $urandom_range(0, INDEX_MAX),
                                          1'($urandom_range(0, 1))));
         end else if (r < 75) begin
            // reads mostly just behind the cursor where text has landed
            repeat ($urandom_range(1, 6)) begin
               q = $urandom_range(0, 9);
               if (q < 7) begin
                  cell_sel = cursor_at[term] - 1 - $urandom_range(0, 160);
                  if (cell_sel < 0)
                     cell_sel = $urandom_range(0, CELLS - 1);
               end else if (q < 9) begin
                  cell_sel = $urandom_range(0, CELLS - 1);
               end else begin
                  cell_sel = $urandom_range(CELLS, INDEX_MAX);
               end
               issue_command(command_beat(CMD_READ, term, $urandom_range(0, 255), cell_sel,
                                          1'($urandom_range(0, 1))));
            end
         end else if (r < 87) begin
            // down to the bottom row, then work there so scrolls happen
            walk_to_last_row(term);
            repeat ($urandom_range(1, 4))
               issue_command(command_beat($urandom_range(0, 1) ? CMD_PUT : CMD_NEWLINE, term,
                                          $urandom_range(0, 255), $urandom_range(0, INDEX_MAX),
                                          1'($urandom_range(0, 1))));
         end else if (r < 92) begin
            issue_command(command_beat(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                                       term, $urandom_range(0, 255),
                                       $urandom_range(0, INDEX_MAX),
                                       1'($urandom_range(0, 1))));
         end else if (r < 95) begin
            issue_command(command_beat(CMD_CLEAR, term, $urandom_range(0, 255),
                                       $urandom_range(0, INDEX_MAX),
                                       1'($urandom_range(0, 1))));
         end else begin
            issue_command(command_beat(CMD_W'($urandom_range(CMD_PUT, CMD_READ)), term,
                                       $urandom_range(0, 255), $urandom_range(0, INDEX_MAX),
                                       1'($urandom_range(0, 1))));
         end
      end
   endtask

   // Random traffic in phases, the visible terminal changed between them;
   // one phase runs with no gaps on either side.
   task automatic test_random_traffic();
      select_display(0);
      run_random_phase(100);
      select_display(3);
      steady = 1'b1;
      run_random_phase(50);
      steady = 1'b0;
      select_display(1);
      run_random_phase(75);
      select_display(2);
      run_random_phase(75);
   endtask

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   initial begin : sequencer
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_CLEAR;
      req_bus.target_terminal = '0;
      req_bus.char_value      = '0;
      req_bus.cell_index      = '0;
      req_bus.end_of_run      = 1'b0;
      csr_bus.valid           = 1'b0;
      csr_bus.data            = '0;
      for (int i = 0; i < MEM_DEPTH; i++)
         screen_mem[i] = BLANK;
      for (int i = 0; i < TERMINALS; i++)
         cursor_at[i] = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // engine sits in its clearing pass first; req ready holds us off
      test_idle_screens();
      select_display(3);
      test_edit_commands();
      test_clear_screen();
      select_display(1);
      test_scroll_edges();
      select_display(2);
      test_back_pressure();
      test_random_traffic();

      drain_results();
      // keep watching to catch any stray result beat
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("[text_console_screen_engine_top] OK");
      else
         $display("[text_console_screen_engine_top] ERROR");
      $finish;
   end

endmodule

// File: sim.f
design/tcse_pkg.sv
design/tcse_req_if.sv
design/tcse_rsp_if.sv
design/tcse_csr_if.sv
design/tcse_ctrl.sv
design/tcse_datapath.sv
design/text_console_screen_engine_top.sv
dv/text_console_screen_engine_top_test.sv
